### design/scrolled_tilemap_cell_renderer_macros.svh
// Assertion macros for the tilemap cell renderer checker.
`ifndef SCROLLED_TILEMAP_CELL_RENDERER_MACROS_SVH
`define SCROLLED_TILEMAP_CELL_RENDERER_MACROS_SVH

// a |-> b on every clock edge outside reset
`define STCR_ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");

// a |=> b on every clock edge outside reset
`define STCR_ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");

`endif

### design/stcr_pkg.sv
`default_nettype none
package stcr_pkg;
	localparam int SCREEN_HEIGHT    = 224;
	localparam int NAME_TABLE_WORDS = 32768;
	localparam int PATTERN_ROWS     = 65536;
	localparam int NT_AW            = $clog2(NAME_TABLE_WORDS);
	localparam int PS_AW            = $clog2(PATTERN_ROWS);

	typedef enum logic [1:0] {
		OP_NAME  = 2'd0,
		OP_PAT   = 2'd1,
		OP_DRAW  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_PAGE   = 3'd0,
		REG_SX     = 3'd1,
		REG_SY     = 3'd2,
		REG_RSX    = 3'd3,
		REG_CSY    = 3'd4,
		REG_CLAMP  = 3'd5,
		REG_WIDTH  = 3'd6,
		REG_BANKS  = 3'd7
	} reg_t;

	// controller -> datapath
	typedef struct packed {
		logic wr_name;   // write name table from the input item
		logic wr_pat;    // write pattern store from the input item
		logic setup;     // compute placement and name table address
		logic check;     // entry data valid: evaluate draw decision
		logic row_read;  // issue pattern read for current row
		logic row_load;  // load fetched row into the shifter
		logic pix_step;  // advance one pixel
	} ctl_t;

	// datapath -> controller
	typedef struct packed {
		logic visible;   // cell overlaps screen (valid after setup)
		logic draw;      // entry passes priority and code test
		logic row_ok;    // current row is on screen
		logic last_row;  // current row is row 7
		logic last_pix;  // current pixel is pixel 7
		logic more;      // row walk of the current cell still in progress
	} sts_t;
endpackage
`default_nettype wire

### design/stcr_datapath.sv
`default_nettype none
module stcr_datapath (
	input  wire                 clk,
	input  wire                 arst_n,
	input  stcr_pkg::ctl_t      ctl,
	output stcr_pkg::sts_t      sts,
	input  wire  [15:0]         store_address,
	input  wire  [31:0]         write_data,
	input  wire  [6:0]          cell_column,
	input  wire  [5:0]          cell_row,
	input  wire                 priority_select,
	input  wire                 cfg_we,
	input  wire  [2:0]          cfg_index,
	input  wire  [15:0]         cfg_data,
	output logic                pix_valid,
	output logic [8:0]          pixel_x,
	output logic [7:0]          pixel_y,
	output logic [9:0]          pixel_colour,
	output logic                last
);
	import stcr_pkg::*;

	logic [15:0] page_q, sx_q, sy_q, rsx_q, csy_q;
	logic [9:0]  clamp_q, width_q;
	logic [1:0]  banks_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_q  <= '0;
			sx_q    <= '0;
			sy_q    <= '0;
			rsx_q   <= '0;
			csy_q   <= '0;
			clamp_q <= 10'd192;
			width_q <= 10'd320;
			banks_q <= 2'd2;
		end else if (cfg_we) begin
			unique case (reg_t'(cfg_index))
				REG_PAGE:  page_q  <= cfg_data;
				REG_SX:    sx_q    <= cfg_data;
				REG_SY:    sy_q    <= cfg_data;
				REG_RSX:   rsx_q   <= cfg_data;
				REG_CSY:   csy_q   <= cfg_data;
				REG_CLAMP: clamp_q <= cfg_data[9:0];
				REG_WIDTH: width_q <= cfg_data[9:0];
				REG_BANKS: banks_q <= cfg_data[1:0];
				default:   ;
			endcase
		end
	end

	// memories
	logic [15:0] name_mem [NAME_TABLE_WORDS];
	logic [31:0] pat_mem  [PATTERN_ROWS];
	logic [15:0] entry_q;
	logic [31:0] row_data_q;
	logic [NT_AW-1:0] nt_addr;
	logic [PS_AW-1:0] ps_raddr;
	logic        ps_in_range;

	always_ff @(posedge clk) begin
		if (ctl.wr_name && {16'd0, store_address} < 32'(NAME_TABLE_WORDS))
			name_mem[store_address[NT_AW-1:0]] <= write_data[15:0];
		if (ctl.setup)
			entry_q <= name_mem[nt_addr];
	end
	always_ff @(posedge clk) begin
		if (ctl.wr_pat && {16'd0, store_address} < 32'(PATTERN_ROWS))
			pat_mem[store_address[PS_AW-1:0]] <= write_data;
		if (ctl.row_read)
			row_data_q <= pat_mem[ps_raddr];
	end

	// placement
	logic [15:0] xs, ys;
	logic signed [11:0] clamp_s, x0, y0, x_q, y_q, xw, width_s, height_s;
	logic [9:0]  xoff;
	logic        pri_q;
	logic [3:0]  page;

	assign xs       = sx_q[15] ? rsx_q : sx_q;
	assign ys       = sy_q[15] ? csy_q : sy_q;
	assign clamp_s  = {{2{clamp_q[9]}}, clamp_q};
	assign width_s  = (width_q > 10'd512) ? 12'sd512 : $signed({2'b00, width_q});
	assign height_s = $signed(12'(SCREEN_HEIGHT));
	assign xoff     = clamp_q - xs[9:0];
	always_comb begin
		x0 = $signed({2'b00, cell_column, 3'b000}) - $signed({2'b00, xoff});
		if (x0 < -clamp_s) x0 = x0 + 12'sd1024;
		y0 = $signed({3'b000, cell_row, 3'b000}) - $signed({3'b000, ys[8:0]});
		if (y0 < -12'sd288) y0 = y0 + 12'sd512;
		unique case ({cell_row[5], cell_column[6]})
			2'b00:   page = page_q[3:0];
			2'b01:   page = page_q[7:4];
			2'b10:   page = page_q[11:8];
			default: page = page_q[15:12];
		endcase
	end
	logic [15:0] word;
	assign word    = {1'b0, page, cell_row[4:0], cell_column[5:0]};
	assign nt_addr = word[NT_AW-1:0];
	logic word_ok_q;

	logic visible_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visible_q <= 1'b0;
		end else if (ctl.setup) begin
			visible_q <= !(x0 <= -12'sd8 || x0 >= width_s || y0 < -12'sd7 ||
				y0 >= height_s);
		end
	end
	always_ff @(posedge clk) begin
		if (ctl.setup) begin
			x_q       <= x0;
			y_q       <= y0;
			pri_q     <= priority_select;
			word_ok_q <= {16'd0, word} < 32'(NAME_TABLE_WORDS);
		end
	end

	// entry decode
	logic [15:0] entry;
	logic [12:0] code;
	logic        bank;
	assign entry = word_ok_q ? entry_q : 16'd0;
	assign bank  = entry[12] ? banks_q[1] : banks_q[0];
	assign code  = {bank, entry[11:0]};
	logic [12:0] code_q;
	logic [6:0]  colour_q;
	logic        draw_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) draw_q <= 1'b0;
		else if (ctl.check) draw_q <= (entry[15] == pri_q) && (code != 13'd0);
	end
	always_ff @(posedge clk) begin
		if (ctl.check) begin
			code_q   <= code;
			colour_q <= entry[12:6];
		end
	end

	// row and pixel walk
	logic [2:0]  r_q, i_q;
	logic [15:0] pidx;
	assign pidx        = {code_q, r_q};
	assign ps_raddr    = pidx[PS_AW-1:0];
	assign ps_in_range = {16'd0, pidx} < 32'(PATTERN_ROWS);
	logic range_s1;
	logic signed [11:0] py;
	assign py = y_q + $signed({9'd0, r_q});

	always_ff @(posedge clk) begin
		if (ctl.check) r_q <= '0;
		else if (ctl.pix_step && i_q == 3'd7) r_q <= r_q + 3'd1;
		else if (ctl.row_load && !sts.row_ok) r_q <= r_q + 3'd1;
		if (ctl.row_read) range_s1 <= ps_in_range;
	end

	// pixel mask for the loaded row: non-zero and on screen
	logic [31:0] bits_q;
	logic [7:0]  mask_q, rowmask;
	always_comb begin
		for (int k = 0; k < 8; k++) begin
			xw = x_q + 12'(k);
			rowmask[k] = (row_data_q[31-4*k -: 4] != 4'd0) && (xw >= 0) && (xw < width_s)
				&& range_s1;
		end
	end
	always_ff @(posedge clk) begin
		if (ctl.row_load) begin
			bits_q <= row_data_q;
			mask_q <= rowmask;
			i_q    <= '0;
		end else if (ctl.pix_step) begin
			i_q <= i_q + 3'd1;
		end
	end

	// each hit is held back until the next hit, so the final pixel of the cell is
	// known when the walk ends and can carry last
	logic [3:0]  cur_pix;
	assign cur_pix = bits_q[31-4*i_q -: 4];

	logic        hold_v_q;
	logic [8:0]  hold_x_q;
	logic [7:0]  hold_y_q;
	logic [9:0]  hold_c_q;
	logic        hit;
	assign hit = ctl.pix_step && mask_q[i_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_v_q  <= 1'b0;
			pix_valid <= 1'b0;
			last      <= 1'b0;
		end else begin
			pix_valid <= 1'b0;
			last      <= 1'b0;
			if (ctl.check) hold_v_q <= 1'b0;
			if (hit) begin
				hold_v_q  <= 1'b1;
				pix_valid <= hold_v_q;
			end else if (sts.more == 1'b0 && hold_v_q && !ctl.check) begin
				// end of cell: flush held pixel as final
				pix_valid <= 1'b1;
				last      <= 1'b1;
				hold_v_q  <= 1'b0;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (hit || (!sts.more && hold_v_q)) begin
			pixel_x      <= hold_x_q;
			pixel_y      <= hold_y_q;
			pixel_colour <= hold_c_q;
		end
		if (hit) begin
			hold_x_q <= 9'(x_q + 12'(i_q));
			hold_y_q <= py[7:0];
			hold_c_q <= {colour_q, 3'b000} + {6'd0, cur_pix};
		end
	end

	assign sts.visible  = visible_q;
	assign sts.draw     = draw_q;
	assign sts.row_ok   = (py >= 0) && (py < height_s);
	assign sts.last_row = (r_q == 3'd7);
	assign sts.last_pix = (i_q == 3'd7);
	assign sts.more     = ctl.row_read || ctl.row_load || ctl.pix_step;
endmodule
`default_nettype wire

### design/stcr_ctrl.sv
`default_nettype none
module stcr_ctrl (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            start,
	input  wire  [1:0]     operation,
	input  stcr_pkg::sts_t sts,
	output stcr_pkg::ctl_t ctl,
	output logic           busy
);
	import stcr_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_ENTRY = 7'b0000010,
		S_CHECK = 7'b0000100,
		S_READ  = 7'b0001000,
		S_LOAD  = 7'b0010000,
		S_PIX   = 7'b0100000,
		S_FLUSH = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic   take;
	assign take = start && !busy;
	assign busy = (state_q != S_IDLE);

	always_comb begin
		ctl     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (take) begin
					ctl.wr_name = (op_t'(operation) == OP_NAME);
					ctl.wr_pat  = (op_t'(operation) == OP_PAT);
					if (op_t'(operation) == OP_DRAW) begin
						ctl.setup = 1'b1;
						state_d   = S_ENTRY;
					end
				end
			end
			S_ENTRY: state_d = sts.visible ? S_CHECK : S_IDLE;
			S_CHECK: begin
				ctl.check = 1'b1;
				state_d   = S_READ;
			end
			S_READ: begin
				if (!sts.draw) begin
					state_d = S_IDLE;
				end else begin
					ctl.row_read = 1'b1;
					state_d      = S_LOAD;
				end
			end
			S_LOAD: begin
				ctl.row_load = 1'b1;
				if (sts.row_ok) state_d = S_PIX;
				else state_d = sts.last_row ? S_FLUSH : S_READ;
			end
			S_PIX: begin
				ctl.pix_step = 1'b1;
				if (sts.last_pix) state_d = sts.last_row ? S_FLUSH : S_READ;
			end
			S_FLUSH: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end
endmodule
`default_nettype wire

### design/scrolled_tilemap_cell_renderer.sv
`default_nettype none
// Tilemap cell renderer. Start an item with start while busy is low; write
// items never raise busy. A render item holds busy for the entry state alone
// when the cell is off screen, for entry, check and read when the entry fails
// the priority or code test, else for entry, check, a pattern read, row load
// and eight pixel steps per on-screen row, a read and load per off-screen row
// and a final flush. Results leave one pixel per strobe cycle, pixel_valid
// marks them and the receiver cannot stall: take every strobe. The final pixel
// of a cell carries last; it appears in the first cycle after busy falls.
// Configuration writes are taken at any edge with cfg_we high but must only
// be issued while no item is in flight. The stores are not cleared at reset.
module scrolled_tilemap_cell_renderer (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire  [1:0]  operation,
	input  wire  [15:0] store_address,
	input  wire  [31:0] write_data,
	input  wire  [6:0]  cell_column,
	input  wire  [5:0]  cell_row,
	input  wire         priority_select,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [15:0] cfg_data,
	output logic        pixel_valid,
	output logic [8:0]  pixel_x,
	output logic [7:0]  pixel_y,
	output logic [9:0]  pixel_colour,
	output logic        last
);
	import stcr_pkg::*;

	ctl_t ctl;
	sts_t sts;

	// sequencer: one state per fetch or pixel step
	stcr_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .operation(operation),
		.sts(sts), .ctl(ctl), .busy(busy)
	);

	// stores, scroll arithmetic and pixel output
	stcr_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .ctl(ctl), .sts(sts),
		.store_address(store_address),
		.write_data(write_data), .cell_column(cell_column), .cell_row(cell_row),
		.priority_select(priority_select), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data),
		.pix_valid(pixel_valid), .pixel_x(pixel_x), .pixel_y(pixel_y),
		.pixel_colour(pixel_colour), .last(last)
	);
endmodule
`default_nettype wire

### design/stcr_checker.sv
`default_nettype none
`include "scrolled_tilemap_cell_renderer_macros.svh"
module stcr_checker (
	input wire       clk,
	input wire       arst_n,
	input wire       start,
	input wire       busy,
	input wire [1:0] operation,
	input wire       pixel_valid,
	input wire       last,
	input wire [7:0] pixel_y
);
	import stcr_pkg::*;
	// last only rides on a strobe
	`STCR_ASSERT_IMP(a_last_valid, clk, arst_n, last, pixel_valid)
	// a write item never leaves the block busy
	`STCR_ASSERT_NEXT(a_write_fast, clk, arst_n, start && !busy && operation != OP_DRAW, !busy)
	// a render item always goes busy
	`STCR_ASSERT_NEXT(a_draw_busy, clk, arst_n, start && !busy && operation == OP_DRAW, busy)
	// pixels stay on screen lines
	`STCR_ASSERT_IMP(a_y_range, clk, arst_n, pixel_valid, pixel_y < 8'(SCREEN_HEIGHT))
endmodule

bind scrolled_tilemap_cell_renderer stcr_checker u_chk (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .operation(operation),
	.pixel_valid(pixel_valid), .last(last), .pixel_y(pixel_y)
);
`default_nettype wire
